// ===== rtl/dac_pkg.sv =====
package dac_pkg;

  localparam int MEM_WORDS_DEF = 100;
  localparam int WORD_BITS_DEF = 32;

  localparam int FUNC_BITS   = 1;
  localparam int LADDR_BITS  = 7;
  localparam int VALUE_BITS  = 32;
  localparam int INBOX_BITS  = 10;
  localparam int STATUS_BITS = 3;
  localparam int PC_BITS     = 7;
  localparam int ADDR_BITS   = 7;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_BITS-1:0] FUNC_STEP = 1'b1;

  localparam logic [INBOX_BITS-1:0] INBOX_MAX = 10'd999;

  localparam int unsigned DIV25_MUL      = 32'd1374389535;
  localparam int          DIV25_MUL_BITS = 31;
  localparam int          DIV25_SHIFT    = 35;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_LOADED   = 3'd0,
    ST_EXECUTED = 3'd1,
    ST_OUTPUT   = 3'd2,
    ST_HALTED   = 3'd3,
    ST_FAULTED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_HALT,
    OP_FAULT,
    OP_ADD,
    OP_SUB,
    OP_STORE,
    OP_LOAD,
    OP_JMP,
    OP_BRZ,
    OP_BRNZ,
    OP_IN,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ADDR_BITS-1:0] addr;
  } dec_t;

endpackage

// ===== rtl/dac_if.sv =====
interface dac_in_if;
  import dac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_BITS-1:0]  func;
  logic [LADDR_BITS-1:0] load_address;
  logic [VALUE_BITS-1:0] load_value;
  logic [INBOX_BITS-1:0] inbox_value;

  modport source (output valid, func, load_address, load_value, inbox_value, input ready);
  modport sink (input valid, func, load_address, load_value, inbox_value, output ready);
endinterface

interface dac_out_if;
  import dac_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [VALUE_BITS-1:0]  out_value;
  logic [PC_BITS-1:0]     pc_after;
  logic [VALUE_BITS-1:0]  acc_after;
  logic [VALUE_BITS-1:0]  fault_word;

  modport source (output valid, status, out_value, pc_after, acc_after, fault_word,
                  input ready);
  modport sink (input valid, status, out_value, pc_after, acc_after, fault_word,
                output ready);
endinterface

// ===== rtl/decimal_accumulator_cpu_step_core.sv =====
// Decimal accumulator machine with a mailbox memory, one word per input handshake.
// The input channel carries a word with func, load_address, load_value and
// inbox_value; a load word writes one mailbox, a step word executes one
// instruction. Every input word gives exactly one result word on the output
// channel with status, out_value, pc_after, acc_after and fault_word.
// A new input word is taken only while the sequencer is idle. A load word
// goes straight to the done state. A step word passes through fetch, divide
// and execute, with an extra operand read when the instruction reads an
// operand (add, subtract, load), and goes from fetch straight to done while
// the machine is stopped; the memory has a single read port, and a reciprocal
// multiply splits the word by 100. The result then sits in the output
// register, and the next input word is taken while it waits there.
// If the receiver stalls with a result still held, the next result waits in
// the sequencer until the output register frees up.
// Reset clears the accumulator, the program counter, the stopped flag and the
// valid bits of the mailbox memory, so every mailbox reads as zero until
// written; there is no clearing pass. After a halt or a fault, steps report
// halted until the next reset.
module decimal_accumulator_cpu_step_core #(
  parameter int MEM_WORDS = dac_pkg::MEM_WORDS_DEF,
  parameter int WORD_BITS = dac_pkg::WORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dac_in_if.sink    in_ch,
  dac_out_if.source out_ch
);
  import dac_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = WORD_BITS - 2 + DIV25_MUL_BITS;
  localparam int QW = WORD_BITS - 6;
  localparam int XW = WORD_BITS - 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIV,
    S_EXEC,
    S_OPER,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   stopped_r, stopped_nxt;
  logic [AW-1:0]          pc_r, pc_nxt;
  logic [WORD_BITS-1:0]   acc_r, acc_nxt;
  logic [MEM_WORDS-1:0]   valid_r, valid_nxt;
  logic                   rd_valid_r, rd_valid_nxt;
  logic [INBOX_BITS-1:0]  inbox_r, inbox_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [ADDR_BITS-1:0]   rem_r, rem_nxt;
  op_t                    op_r, op_nxt;
  status_t                status_r, status_nxt;
  logic [WORD_BITS-1:0]   outv_r, outv_nxt;
  logic [WORD_BITS-1:0]   fword_r, fword_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [VALUE_BITS-1:0]  out_value_r, out_value_nxt;
  logic [PC_BITS-1:0]     out_pc_r, out_pc_nxt;
  logic [VALUE_BITS-1:0]  out_acc_r, out_acc_nxt;
  logic [VALUE_BITS-1:0]  out_fword_r, out_fword_nxt;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WORD_BITS-1:0]   mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [WORD_BITS-1:0]   mem_rdata;
  logic [WORD_BITS-1:0]   rd_word;
  logic [QW-1:0]          quot;
  logic [XW-1:0]          rem25;
  logic [AW-1:0]          pc_adv;
  logic [AW-1:0]          target;
  logic [INBOX_BITS-1:0]  inbox_sat;
  dec_t                   dec;

  dac_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dac_decode #(
    .MEM_WORDS(MEM_WORDS),
    .WORD_BITS(WORD_BITS)
  ) u_decode (
    .word(word_r),
    .rem (rem_r),
    .dec (dec)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.pc_after   = out_pc_r;
  assign out_ch.acc_after  = out_acc_r;
  assign out_ch.fault_word = out_fword_r;

  // A mailbox that was never written since reset reads as zero.
  assign rd_word   = rd_valid_r ? mem_rdata : '0;
  assign quot      = prod_r[DIV25_SHIFT +: QW];
  assign rem25     = word_r[WORD_BITS-1:2] - XW'(quot) * XW'(25);
  assign pc_adv    = (pc_r == AW'(MEM_WORDS - 1)) ? '0 : pc_r + AW'(1);
  assign target    = dec.addr[AW-1:0];
  assign inbox_sat = (inbox_r > INBOX_MAX) ? INBOX_MAX : inbox_r;

  always_comb begin
    state_nxt      = state_r;
    stopped_nxt    = stopped_r;
    pc_nxt         = pc_r;
    acc_nxt        = acc_r;
    valid_nxt      = valid_r;
    inbox_nxt      = inbox_r;
    word_nxt       = word_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    outv_nxt       = outv_r;
    fword_nxt      = fword_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pc_nxt     = out_pc_r;
    out_acc_nxt    = out_acc_r;
    out_fword_nxt  = out_fword_r;
    mem_we         = 1'b0;
    mem_waddr      = pc_r;
    mem_wdata      = acc_r;
    mem_raddr      = pc_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          inbox_nxt = in_ch.inbox_value;
          outv_nxt  = '0;
          fword_nxt = '0;
          if (in_ch.func == FUNC_LOAD) begin
            status_nxt = ST_LOADED;
            if (in_ch.load_address < LADDR_BITS'(MEM_WORDS)) begin
              mem_we    = 1'b1;
              mem_waddr = in_ch.load_address[AW-1:0];
              mem_wdata = in_ch.load_value[WORD_BITS-1:0];
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        word_nxt = rd_word;
        prod_nxt = PW'(rd_word[WORD_BITS-1:2]) * PW'(DIV25_MUL);
        if (stopped_r) begin
          status_nxt = ST_HALTED;
          fword_nxt  = rd_word;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt   = {rem25[4:0], word_r[1:0]};
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        status_nxt = ST_EXECUTED;
        pc_nxt     = pc_adv;
        state_nxt  = S_DONE;
        case (dec.op)
          OP_HALT: begin
            stopped_nxt = 1'b1;
            status_nxt  = ST_HALTED;
            fword_nxt   = word_r;
            pc_nxt      = pc_r;
          end
          OP_FAULT: begin
            stopped_nxt = 1'b1;
            status_nxt  = ST_FAULTED;
            fword_nxt   = word_r;
            pc_nxt      = pc_r;
          end
          OP_IN: begin
            acc_nxt = WORD_BITS'(inbox_sat);
          end
          OP_OUT: begin
            outv_nxt   = acc_r;
            status_nxt = ST_OUTPUT;
          end
          OP_JMP: begin
            pc_nxt = target;
          end
          OP_BRZ: begin
            pc_nxt = (acc_r == '0) ? target : pc_adv;
          end
          OP_BRNZ: begin
            pc_nxt = (acc_r != '0) ? target : pc_adv;
          end
          OP_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = target;
            mem_wdata = acc_r;
          end
          OP_ADD, OP_SUB, OP_LOAD: begin
            mem_raddr = target;
            op_nxt    = dec.op;
            pc_nxt    = pc_r;
            state_nxt = S_OPER;
          end
          default: begin
            pc_nxt = pc_r;
          end
        endcase
      end
      S_OPER: begin
        case (op_r)
          OP_ADD:  acc_nxt = acc_r + rd_word;
          OP_SUB:  acc_nxt = acc_r - rd_word;
          default: acc_nxt = rd_word;
        endcase
        pc_nxt    = pc_adv;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = VALUE_BITS'(outv_r);
          out_pc_nxt     = PC_BITS'(pc_r);
          out_acc_nxt    = VALUE_BITS'(acc_r);
          out_fword_nxt  = VALUE_BITS'(fword_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mem_we) begin
      valid_nxt[mem_waddr] = 1'b1;
    end
    rd_valid_nxt = valid_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stopped_r   <= 1'b0;
      pc_r        <= '0;
      acc_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stopped_r   <= stopped_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_valid_r   <= rd_valid_nxt;
    inbox_r      <= inbox_nxt;
    word_r       <= word_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    outv_r       <= outv_nxt;
    fword_r      <= fword_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pc_r     <= out_pc_nxt;
    out_acc_r    <= out_acc_nxt;
    out_fword_r  <= out_fword_nxt;
  end

`ifndef SYNTH
  a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pc_r} < (AW+1)'(MEM_WORDS))
    else $error("program counter beyond memory depth");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("finished word not placed in output register");

  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (status_r == ST_HALTED || status_r == ST_FAULTED)) |-> stopped_r)
    else $error("halted or faulted status while running");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_EXEC || state_r == S_OPER) |=> $stable(acc_r))
    else $error("accumulator changed outside execute");
`endif

endmodule

// ===== rtl/dac_ram.sv =====
module dac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dac_decode.sv =====
module dac_decode #(
  parameter int MEM_WORDS = dac_pkg::MEM_WORDS_DEF,
  parameter int WORD_BITS = dac_pkg::WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]          word,
  input  logic [dac_pkg::ADDR_BITS-1:0] rem,
  output dac_pkg::dec_t                 dec
);
  import dac_pkg::*;

  localparam int NQ = 99 / MEM_WORDS + 1;

  logic [ADDR_BITS-1:0] addr;

  // The remainder is below 100, so only a few multiples of the depth are candidates.
  always_comb begin
    addr = rem;
    for (int k = 0; k < NQ; k++) begin
      if ({1'b0, rem} >= 8'(k * MEM_WORDS) && {1'b0, rem} < 8'((k + 1) * MEM_WORDS)) begin
        addr = rem - ADDR_BITS'(k * MEM_WORDS);
      end
    end
  end

  always_comb begin
    dec.addr = addr;
    if (word[WORD_BITS-1]) begin
      dec.op = OP_FAULT;
    end else if (word >= WORD_BITS'(900)) begin
      if (rem == ADDR_BITS'(1)) begin
        dec.op = OP_IN;
      end else if (rem == ADDR_BITS'(2)) begin
        dec.op = OP_OUT;
      end else begin
        dec.op = OP_FAULT;
      end
    end else if (word >= WORD_BITS'(800)) begin
      dec.op = OP_BRNZ;
    end else if (word >= WORD_BITS'(700)) begin
      dec.op = OP_BRZ;
    end else if (word >= WORD_BITS'(600)) begin
      dec.op = OP_JMP;
    end else if (word >= WORD_BITS'(500)) begin
      dec.op = OP_LOAD;
    end else if (word >= WORD_BITS'(400)) begin
      dec.op = OP_FAULT;
    end else if (word >= WORD_BITS'(300)) begin
      dec.op = OP_STORE;
    end else if (word >= WORD_BITS'(200)) begin
      dec.op = OP_SUB;
    end else if (word >= WORD_BITS'(100)) begin
      dec.op = OP_ADD;
    end else if (word == '0) begin
      dec.op = OP_HALT;
    end else begin
      dec.op = OP_FAULT;
    end
  end

endmodule
